// File: sv/cflc_pkg.sv
`default_nettype none

package cflc_pkg;

  localparam int SLOT_COUNT  = 32;
  localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ID_W        = 29;
  localparam int DATA_W      = 64;
  localparam int LEN_W       = 4;
  localparam int ENTRY_W     = DATA_W + LEN_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [LEN_W-1:0] MAX_LENGTH = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   identifier;
    logic [DATA_W-1:0] frame_data;
    logic [LEN_W-1:0]  frame_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] read_data;
    logic [LEN_W-1:0]  read_length;
  } out_item_t;

  typedef struct packed {
    logic              kind;
    logic              id_zero;
    logic [ID_W-1:0]   identifier;
    logic [DATA_W-1:0] frame_data;
    logic [LEN_W-1:0]  frame_length;
  } q_item_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOOK,
    B_ACT,
    B_RD
  } back_state_t;

  function automatic logic [SLOT_W-1:0] slot_encode(input logic [SLOT_COUNT-1:0] oh);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (oh[i]) idx = idx | i[SLOT_W-1:0];
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: sv/can_frame_latest_cache.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+------------------------------------------------
// in       | in_valid / in_stall | in_item: kind, identifier, frame_data, frame_length
// out      | out_valid/out_stall | out_item: status, read_data, read_length
//
// Back end: each received frame, and each read without a stored frame, passes
// the lookup and act states; a read that returns a frame then waits in the
// read state for the payload RAM's registered read. The slot lookup is a set of
// parallel key compares, registered; the act state then updates the slot or
// issues the read. An idle block pops the queue before the lookup. Reset clears
// all slot keys and frame flags at once, no sweep. A 2-entry queue decouples
// intake from lookup; a stalled result holds reads, while frames and intake go on.
`default_nettype none

module can_frame_latest_cache
  import cflc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  logic    q_full;
  logic    q_push;
  q_item_t q_push_item;
  logic    q_pop;
  logic    q_valid;
  q_item_t q_item;

  cflc_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_item (q_push_item)
  );

  cflc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  cflc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: sv/cflc_ram.sv
`default_nettype none

module cflc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: sv/cflc_front.sv
`default_nettype none

module cflc_front
  import cflc_pkg::*;
(
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  input  wire logic     q_full,
  output logic          q_push,
  output q_item_t       q_push_item
);

  logic id_zero;
  logic drop;

  assign id_zero  = (in_item.identifier == '0);
  // frames on the reserved identifier are discarded here
  assign drop     = (in_item.kind == KIND_FRAME) && id_zero;
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && !drop;

  always_comb begin
    q_push_item.kind         = in_item.kind;
    q_push_item.id_zero      = id_zero;
    q_push_item.identifier   = in_item.identifier;
    q_push_item.frame_data   = in_item.frame_data;
    q_push_item.frame_length = (in_item.frame_length > MAX_LENGTH) ? MAX_LENGTH
                                                                    : in_item.frame_length;
  end

endmodule

`default_nettype wire

// File: sv/cflc_queue.sv
`default_nettype none

module cflc_queue
  import cflc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire q_item_t push_item,
  output logic         full,
  input  wire logic    pop,
  output logic         q_valid,
  output q_item_t      q_item
);

  q_item_t             entries_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = entries_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: sv/cflc_back.sv
`default_nettype none

module cflc_back
  import cflc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    q_valid,
  input  wire q_item_t q_item,
  output logic         q_pop,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_item_t    out_item
);

  back_state_t           state_r, state_nxt;
  q_item_t               item_r, item_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;
  logic [ID_W-1:0]       key_r [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] has_frame_r;
  logic [SLOT_COUNT-1:0] hit_oh_r;
  logic [SLOT_COUNT-1:0] free_oh_r;

  logic [SLOT_COUNT-1:0] match;
  logic [SLOT_COUNT-1:0] free;
  logic [SLOT_COUNT-1:0] free_low;
  logic                  hit_any;
  logic                  hit_has_frame;
  logic                  free_any;
  logic                  out_free;
  logic                  fetch;
  logic                  key_we;
  logic                  hf_set;
  logic                  ram_we;
  logic                  ram_re;
  logic [SLOT_W-1:0]     hit_idx;
  logic [ENTRY_W-1:0]    ram_rdata;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match[i] = (key_r[i] == item_r.identifier);
      free[i]  = (key_r[i] == '0);
    end
  end

  // isolate the lowest free slot
  assign free_low      = free & (~free + SLOT_COUNT'(1));
  assign hit_any       = |hit_oh_r;
  assign hit_has_frame = |(hit_oh_r & has_frame_r);
  assign free_any      = |free_oh_r;
  assign hit_idx       = slot_encode(hit_oh_r);
  assign out_free      = !out_valid_r || !out_stall;

  cflc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hit_idx),
    .wdata ({item_r.frame_data, item_r.frame_length}),
    .re    (ram_re),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    q_pop         = 1'b0;
    fetch         = 1'b0;
    key_we        = 1'b0;
    hf_set        = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        fetch = 1'b1;
      end
      B_LOOK: begin
        state_nxt = B_ACT;
      end
      B_ACT: begin
        if (item_r.kind == KIND_FRAME) begin
          if (hit_any) begin
            ram_we = 1'b1;
            hf_set = 1'b1;
          end
          fetch = 1'b1;
        end else if (!item_r.id_zero && hit_any && hit_has_frame) begin
          ram_re    = 1'b1;
          state_nxt = B_RD;
        end else if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.read_data   = '0;
          out_item_nxt.read_length = '0;
          if (item_r.id_zero || hit_any || free_any) begin
            out_item_nxt.status = ST_EMPTY;
          end else begin
            out_item_nxt.status = ST_FULL;
          end
          key_we = !item_r.id_zero && !hit_any && free_any;
          fetch  = 1'b1;
        end
      end
      B_RD: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.status      = ST_OK;
          out_item_nxt.read_data   = ram_rdata[ENTRY_W-1:LEN_W];
          out_item_nxt.read_length = ram_rdata[LEN_W-1:0];
          fetch                    = 1'b1;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    if (fetch) begin
      if (q_valid) begin
        q_pop     = 1'b1;
        item_nxt  = q_item;
        state_nxt = B_LOOK;
      end else begin
        state_nxt = B_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      has_frame_r <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) key_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (hf_set) has_frame_r <= has_frame_r | hit_oh_r;
      else if (key_we) has_frame_r <= has_frame_r & ~free_oh_r;
      if (key_we) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (free_oh_r[i]) key_r[i] <= item_r.identifier;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_item_r <= out_item_nxt;
    if (state_r == B_LOOK) begin
      hit_oh_r  <= match;
      free_oh_r <= free_low;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // identifier zero matches every free slot, so it is left out
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ACT && !item_r.id_zero) |-> $onehot0(hit_oh_r))
    else $error("identifier held by more than one slot");

  a_no_double_register: assert property (@(posedge clk) disable iff (!rst_n)
    key_we |-> (!hit_any && !item_r.id_zero))
    else $error("registering an identifier that already has a slot");

  a_rd_from_act: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RD) |-> ($past(state_r) == B_RD || $past(state_r) == B_ACT))
    else $error("payload read wait entered without a lookup");

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: sim/tb_can_frame_latest_cache.sv
`timescale 1ns / 100ps

module tb_can_frame_latest_cache;
  import cflc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_ITEMS   = 850;
  localparam int POOL_SIZE      = 40;

  localparam logic [ID_W-1:0] ID_LOW  = 29'h0000001;
  localparam logic [ID_W-1:0] ID_HIGH = 29'h1FFFFFFF;
  localparam logic [ID_W-1:0] ID_MID  = 29'h0AAAAAAA;
  localparam logic [ID_W-1:0] ID_NONE = '0;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  logic [ID_W-1:0]   key_tbl  [SLOT_COUNT];
  logic              has_tbl  [SLOT_COUNT];
  logic [DATA_W-1:0] data_tbl [SLOT_COUNT];
  logic [LEN_W-1:0]  len_tbl  [SLOT_COUNT];
  out_item_t         pending_reads[$];

  int mismatch_count = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  can_frame_latest_cache dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int find_key(logic [ID_W-1:0] id);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (key_tbl[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void predict_transfer(in_item_t it);
    int s;
    out_item_t r;
    s = find_key(it.identifier);
    if (it.kind == KIND_FRAME) begin
      if (it.identifier != ID_NONE && s >= 0) begin
        data_tbl[s] = it.frame_data;
        len_tbl[s]  = (it.frame_length > MAX_LENGTH) ? MAX_LENGTH : it.frame_length;
        has_tbl[s]  = 1'b1;
      end
    end else begin
      r.status      = ST_EMPTY;
      r.read_data   = '0;
      r.read_length = '0;
      if (it.identifier != ID_NONE) begin
        if (s < 0) begin
          s = find_key(ID_NONE);
          if (s < 0) begin
            r.status = ST_FULL;
          end else begin
            key_tbl[s] = it.identifier;
            has_tbl[s] = 1'b0;
          end
        end else if (has_tbl[s]) begin
          r.status      = ST_OK;
          r.read_data   = data_tbl[s];
          r.read_length = len_tbl[s];
        end
      end
      pending_reads.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] exp);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, exp);
    mismatch_count++;
  endtask

  task automatic check_read_result(out_item_t got);
    out_item_t exp;
    if (pending_reads.size() == 0) begin
      report_mismatch("unexpected transfer", got.read_data, '0);
      return;
    end
    exp = pending_reads.pop_front();
    if (got.status != exp.status) begin
      report_mismatch("status", DATA_W'(got.status), DATA_W'(exp.status));
    end
    if (got.read_data != exp.read_data) report_mismatch("read_data", got.read_data, exp.read_data);
    if (got.read_length != exp.read_length) begin
      report_mismatch("read_length", DATA_W'(got.read_length), DATA_W'(exp.read_length));
    end
  endtask

  // results are checked before the same edge's input is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_read_result(out_item);
      if (in_valid && !in_stall) predict_transfer(in_item);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // valid stays high across back-to-back transfers
  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame(logic [ID_W-1:0] id, logic [DATA_W-1:0] data,
                            logic [LEN_W-1:0] len);
    in_item_t it;
    it.kind         = KIND_FRAME;
    it.identifier   = id;
    it.frame_data   = data;
    it.frame_length = len;
    send_item(it);
  endtask

  task automatic send_read(logic [ID_W-1:0] id);
    in_item_t it;
    it.kind         = KIND_READ;
    it.identifier   = id;
    it.frame_data   = {$urandom, $urandom};
    it.frame_length = LEN_W'($urandom_range(0, 15));
    send_item(it);
  endtask

  task automatic test_directed_cases();
    send_read(ID_NONE);
    send_frame(ID_NONE, {$urandom, $urandom}, 4'd5);
    send_read(ID_NONE);
    send_frame(ID_LOW, 64'hDEAD_BEEF_0000_0001, 4'd4);
    send_read(ID_LOW);
    send_read(ID_LOW);
    send_frame(ID_LOW, '1, 4'd15);
    send_read(ID_LOW);
    send_frame(ID_LOW, '0, 4'd0);
    send_read(ID_LOW);
    send_read(ID_HIGH);
    send_frame(ID_HIGH, 64'h0123_4567_89AB_CDEF, 4'd9);
    send_frame(ID_HIGH, 64'h8000_0000_0000_0001, 4'd8);
    send_read(ID_HIGH);
    send_read(ID_LOW);
    send_frame(ID_MID, 64'h5555_5555_5555_5555, 4'd3);
    send_read(ID_MID);
    send_frame(ID_MID, 64'hAAAA_AAAA_AAAA_AAAA, 4'd12);
    send_read(ID_MID);
    send_frame(ID_NONE, '1, 4'd15);
    send_read(ID_NONE);
    send_read(ID_HIGH);
  endtask

  // pool is larger than the table, so late misses hit a full table
  task automatic test_random_traffic();
    logic [ID_W-1:0] pool [POOL_SIZE];
    in_item_t it;
    int pick;
    pool[0] = ID_LOW;
    pool[1] = ID_HIGH;
    pool[2] = ID_MID;
    for (int i = 3; i < POOL_SIZE; i++) pool[i] = ID_W'($urandom);
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      it.kind = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 82) it.identifier = pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 94) it.identifier = ID_W'($urandom);
      else it.identifier = ID_NONE;
      it.frame_data = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) it.frame_length = LEN_W'($urandom_range(9, 15));
      else it.frame_length = LEN_W'($urandom_range(0, 8));
      send_item(it);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      key_tbl[i]  = '0;
      has_tbl[i]  = 1'b0;
      data_tbl[i] = '0;
      len_tbl[i]  = '0;
    end
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/cflc_pkg.sv
sv/cflc_ram.sv
sv/cflc_front.sv
sv/cflc_queue.sv
sv/cflc_back.sv
sv/can_frame_latest_cache.sv
sim/tb_can_frame_latest_cache.sv
